@@ sv/cdq_pkg.sv @@
// shared types and constants for the circular deque
package cdq_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int WORD_W        = 32;

    // operation codes carried by kind
    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_REAR  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_REAR   = 2'd3
    } cdq_kind_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } cdq_status_t;

    // controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } cdq_state_t;

endpackage

@@ sv/circular_deque.sv @@
// circular deque: ring store of signed words with push/pop at both ends
// latency: result strobe in the cycle after start is taken, shown for one cycle
// busy: held in the response state, so the next transaction is taken only after
//   the previous result; a pop refills the front or rear word by a memory read
// reset: pointers and count clear asynchronously; storage is not cleared and
//   needs no clearing pass; the receiver cannot stall, so no result is held
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          kind,
    input  logic signed [cdq_pkg::WORD_W-1:0]   data_in,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [cdq_pkg::WORD_W-1:0]   pop_value,
    output logic signed [cdq_pkg::WORD_W-1:0]   front_value,
    output logic signed [cdq_pkg::WORD_W-1:0]   rear_value,
    output logic [CW-1:0]                       occupancy,
    output logic                                is_empty,
    output logic                                is_full
);

    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic signed [cdq_pkg::WORD_W-1:0] mem_wdata;
    logic                              mem_re;
    logic [AW-1:0]                     mem_raddr;
    logic signed [cdq_pkg::WORD_W-1:0] mem_rdata;

    // controller
    cdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .data_in     (data_in),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .pop_value   (pop_value),
        .front_value (front_value),
        .rear_value  (rear_value),
        .occupancy   (occupancy),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // word store; a transaction either writes or reads, never both
    cdq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

@@ sv/cdq_ram.sv @@
// single write port, single read port word store with registered read data
module cdq_ram #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [AW-1:0]                       waddr,
    input  logic signed [cdq_pkg::WORD_W-1:0]   wdata,
    input  logic                                re,
    input  logic [AW-1:0]                       raddr,
    output logic signed [cdq_pkg::WORD_W-1:0]   rdata
);

    logic signed [cdq_pkg::WORD_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/cdq_ctrl.sv @@
// pointer, count and end word cache control for the circular deque
module cdq_ctrl #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [1:0]                          kind,
    input  logic signed [cdq_pkg::WORD_W-1:0]   data_in,
    output logic                                busy,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [cdq_pkg::WORD_W-1:0]   pop_value,
    output logic signed [cdq_pkg::WORD_W-1:0]   front_value,
    output logic signed [cdq_pkg::WORD_W-1:0]   rear_value,
    output logic [CW-1:0]                       occupancy,
    output logic                                is_empty,
    output logic                                is_full,
    output logic                                mem_we,
    output logic [AW-1:0]                       mem_waddr,
    output logic signed [cdq_pkg::WORD_W-1:0]   mem_wdata,
    output logic                                mem_re,
    output logic [AW-1:0]                       mem_raddr,
    input  logic signed [cdq_pkg::WORD_W-1:0]   mem_rdata
);

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT   = CW'(1);

    cdq_pkg::cdq_state_t  state_reg, state_next;
    logic [AW-1:0]        front_ptr_reg, front_ptr_next;
    logic [AW-1:0]        rear_ptr_reg, rear_ptr_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 refresh_front_reg, refresh_front_next;
    logic                 refresh_rear_reg, refresh_rear_next;
    cdq_pkg::cdq_status_t status_reg, status_next;
    logic signed [cdq_pkg::WORD_W-1:0] front_word_reg, front_word_next;
    logic signed [cdq_pkg::WORD_W-1:0] rear_word_reg, rear_word_next;
    logic signed [cdq_pkg::WORD_W-1:0] pop_reg, pop_next;

    logic                 accept;
    logic [AW-1:0]        front_prev, front_succ, rear_prev, rear_succ;
    cdq_pkg::cdq_kind_t   op;

    assign accept = start && (state_reg == cdq_pkg::ST_IDLE);
    assign op     = cdq_pkg::cdq_kind_t'(kind);

    // ring neighbors of both pointers
    assign front_prev = (front_ptr_reg == '0) ? LAST_SLOT : front_ptr_reg - AW'(1);
    assign front_succ = (front_ptr_reg == LAST_SLOT) ? '0 : front_ptr_reg + AW'(1);
    assign rear_prev  = (rear_ptr_reg == '0) ? LAST_SLOT : rear_ptr_reg - AW'(1);
    assign rear_succ  = (rear_ptr_reg == LAST_SLOT) ? '0 : rear_ptr_reg + AW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdq_pkg::ST_IDLE: if (start) state_next = cdq_pkg::ST_RESP;
            cdq_pkg::ST_RESP: state_next = cdq_pkg::ST_IDLE;
            default:          state_next = cdq_pkg::ST_IDLE;
        endcase
    end

    // transaction datapath: pointers, count, caches and memory requests
    always_comb
    begin
        front_ptr_next     = front_ptr_reg;
        rear_ptr_next      = rear_ptr_reg;
        count_next         = count_reg;
        refresh_front_next = 1'b0;
        refresh_rear_next  = 1'b0;
        status_next        = status_reg;
        pop_next           = pop_reg;
        front_word_next    = front_word_reg;
        rear_word_next     = rear_word_reg;
        mem_we             = 1'b0;
        mem_waddr          = '0;
        mem_wdata          = data_in;
        mem_re             = 1'b0;
        mem_raddr          = '0;

        // fold the word fetched for a pop into the end cache
        if (refresh_front_reg)
        begin
            front_word_next = mem_rdata;
        end
        if (refresh_rear_reg)
        begin
            rear_word_next = mem_rdata;
        end

        if (accept)
        begin
            status_next = cdq_pkg::STATUS_DONE;
            pop_next    = '0;
            case (op)
                cdq_pkg::KIND_PUSH_FRONT,
                cdq_pkg::KIND_PUSH_REAR:
                begin
                    if (count_reg == FULL_CNT)
                    begin
                        status_next = cdq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + ONE_CNT;
                        mem_we     = 1'b1;
                        if (count_reg == '0)
                        begin
                            // first word always lands in slot zero
                            front_ptr_next  = '0;
                            rear_ptr_next   = '0;
                            mem_waddr       = '0;
                            front_word_next = data_in;
                            rear_word_next  = data_in;
                        end
                        else if (op == cdq_pkg::KIND_PUSH_FRONT)
                        begin
                            front_ptr_next  = front_prev;
                            mem_waddr       = front_prev;
                            front_word_next = data_in;
                        end
                        else
                        begin
                            rear_ptr_next  = rear_succ;
                            mem_waddr      = rear_succ;
                            rear_word_next = data_in;
                        end
                    end
                end
                cdq_pkg::KIND_POP_FRONT:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = cdq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        pop_next   = front_word_reg;
                        count_next = count_reg - ONE_CNT;
                        if (count_reg > ONE_CNT)
                        begin
                            front_ptr_next     = front_succ;
                            mem_re             = 1'b1;
                            mem_raddr          = front_succ;
                            refresh_front_next = 1'b1;
                        end
                    end
                end
                cdq_pkg::KIND_POP_REAR:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = cdq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        pop_next   = rear_word_reg;
                        count_next = count_reg - ONE_CNT;
                        if (count_reg > ONE_CNT)
                        begin
                            rear_ptr_next     = rear_prev;
                            mem_re            = 1'b1;
                            mem_raddr         = rear_prev;
                            refresh_rear_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= cdq_pkg::ST_IDLE;
            front_ptr_reg     <= '0;
            rear_ptr_reg      <= '0;
            count_reg         <= '0;
            refresh_front_reg <= 1'b0;
            refresh_rear_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            front_ptr_reg     <= front_ptr_next;
            rear_ptr_reg      <= rear_ptr_next;
            count_reg         <= count_next;
            refresh_front_reg <= refresh_front_next;
            refresh_rear_reg  <= refresh_rear_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        pop_reg        <= pop_next;
        front_word_reg <= front_word_next;
        rear_word_reg  <= rear_word_next;
    end

    // handshake outputs from state
    always_comb
    begin
        busy = 1'b0;
        done = 1'b0;
        case (state_reg)
            cdq_pkg::ST_IDLE: busy = 1'b0;
            cdq_pkg::ST_RESP:
            begin
                busy = 1'b1;
                done = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    // result fields, end words bypass the cache while a fetch lands
    assign status      = status_reg;
    assign pop_value   = pop_reg;
    assign occupancy   = count_reg;
    assign is_empty    = (count_reg == '0);
    assign is_full     = (count_reg == FULL_CNT);
    assign front_value = is_empty ? '0 : (refresh_front_reg ? mem_rdata : front_word_reg);
    assign rear_value  = is_empty ? '0 : (refresh_rear_reg ? mem_rdata : rear_word_reg);

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("count above depth");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted transaction without result strobe");

    a_refresh_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (refresh_front_reg || refresh_rear_reg) |-> (state_reg == cdq_pkg::ST_RESP))
        else $error("cache refresh outside response cycle");

    a_one_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        !(refresh_front_reg && refresh_rear_reg))
        else $error("both end caches refreshed at once");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !kind[1] && (count_reg != FULL_CNT))
        |=> (count_reg == $past(count_reg) + ONE_CNT))
        else $error("push did not raise count");

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench for the circular deque: directed table, random mix, ramp and drain
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH           = cdq_pkg::DEPTH_DEFAULT;
    localparam int AW              = $clog2(DEPTH);
    localparam int CW              = $clog2(DEPTH + 1);
    localparam int WATCHDOG_CYCLES = 200;
    localparam int MAX_REPORTS     = 10;

    localparam logic signed [cdq_pkg::WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [cdq_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic [CW-1:0]                     OCC_ONE  = CW'(1);

    // one result transaction as seen on the ports
    typedef struct packed {
        cdq_pkg::cdq_status_t               status;
        logic signed [cdq_pkg::WORD_W-1:0]  pop_value;
        logic signed [cdq_pkg::WORD_W-1:0]  front_value;
        logic signed [cdq_pkg::WORD_W-1:0]  rear_value;
        logic [CW-1:0]                      occupancy;
        logic                               is_empty;
        logic                               is_full;
    } deque_result_t;

    // directed stimulus row, with an optional hand-written result
    typedef struct packed {
        cdq_pkg::cdq_kind_t                 op;
        logic signed [cdq_pkg::WORD_W-1:0]  word;
        logic                               has_want;
        deque_result_t                      want;
    } directed_row_t;

    localparam deque_result_t NO_RESULT    = '0;
    localparam deque_result_t EMPTY_REFUSE =
        '{cdq_pkg::STATUS_EMPTY, '0, '0, '0, '0, 1'b1, 1'b0};

    localparam directed_row_t DIRECTED_ROWS [25] = '{
        // refusals straight out of reset
        '{cdq_pkg::KIND_POP_FRONT, 32'sd0, 1'b1, EMPTY_REFUSE},
        '{cdq_pkg::KIND_POP_REAR,  32'sd0, 1'b1, EMPTY_REFUSE},
        // single-word push and pop of the extremes
        '{cdq_pkg::KIND_PUSH_REAR,  WORD_MAX, 1'b1,
          '{cdq_pkg::STATUS_DONE, '0, WORD_MAX, WORD_MAX, OCC_ONE, 1'b0, 1'b0}},
        '{cdq_pkg::KIND_POP_REAR,   32'sd0,   1'b1,
          '{cdq_pkg::STATUS_DONE, WORD_MAX, '0, '0, '0, 1'b1, 1'b0}},
        '{cdq_pkg::KIND_PUSH_FRONT, WORD_MIN, 1'b1,
          '{cdq_pkg::STATUS_DONE, '0, WORD_MIN, WORD_MIN, OCC_ONE, 1'b0, 1'b0}},
        '{cdq_pkg::KIND_POP_FRONT,  32'sd0,   1'b1,
          '{cdq_pkg::STATUS_DONE, WORD_MIN, '0, '0, '0, 1'b1, 1'b0}},
        '{cdq_pkg::KIND_PUSH_FRONT, -32'sd1,  1'b1,
          '{cdq_pkg::STATUS_DONE, '0, -32'sd1, -32'sd1, OCC_ONE, 1'b0, 1'b0}},
        // front pointer wraps below slot zero, then mixed ends
        '{cdq_pkg::KIND_PUSH_FRONT, 32'sh5555_5555, 1'b0, NO_RESULT},
        '{cdq_pkg::KIND_PUSH_REAR,  32'shAAAA_AAAA, 1'b0, NO_RESULT},
        '{cdq_pkg::KIND_PUSH_REAR,  32'sd0,         1'b0, NO_RESULT},
        '{cdq_pkg::KIND_PUSH_FRONT, WORD_MAX,       1'b0, NO_RESULT},
        '{cdq_pkg::KIND_POP_REAR,   32'sh1234_5678, 1'b0, NO_RESULT},
        '{cdq_pkg::KIND_POP_FRONT,  -32'sd1,        1'b0, NO_RESULT},
        '{cdq_pkg::KIND_POP_FRONT,  32'sd0,         1'b0, NO_RESULT},
        '{cdq_pkg::KIND_POP_REAR,   32'sd0,         1'b0, NO_RESULT},
        '{cdq_pkg::KIND_POP_REAR,   32'sd0,         1'b0, NO_RESULT},
        '{cdq_pkg::KIND_POP_REAR,   32'sd0,         1'b1, EMPTY_REFUSE},
        // push into an emptied queue restarts both pointers at slot zero
        '{cdq_pkg::KIND_PUSH_REAR,  32'sd1, 1'b1,
          '{cdq_pkg::STATUS_DONE, '0, 32'sd1, 32'sd1, OCC_ONE, 1'b0, 1'b0}},
        '{cdq_pkg::KIND_PUSH_FRONT, 32'sd2, 1'b0, NO_RESULT},
        '{cdq_pkg::KIND_POP_REAR,   32'sd0, 1'b0, NO_RESULT},
        '{cdq_pkg::KIND_POP_FRONT,  32'sd0, 1'b1,
          '{cdq_pkg::STATUS_DONE, 32'sd2, '0, '0, '0, 1'b1, 1'b0}},
        '{cdq_pkg::KIND_PUSH_FRONT, WORD_MIN, 1'b1,
          '{cdq_pkg::STATUS_DONE, '0, WORD_MIN, WORD_MIN, OCC_ONE, 1'b0, 1'b0}},
        '{cdq_pkg::KIND_PUSH_REAR,  WORD_MAX, 1'b0, NO_RESULT},
        '{cdq_pkg::KIND_POP_FRONT,  32'sd0,   1'b0, NO_RESULT},
        '{cdq_pkg::KIND_POP_REAR,   32'sd0,   1'b1,
          '{cdq_pkg::STATUS_DONE, WORD_MAX, '0, '0, '0, 1'b1, 1'b0}}
    };

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [1:0]                         kind;
    logic signed [cdq_pkg::WORD_W-1:0]  data_in;
    logic                               done;
    logic [1:0]                         status;
    logic signed [cdq_pkg::WORD_W-1:0]  pop_value;
    logic signed [cdq_pkg::WORD_W-1:0]  front_value;
    logic signed [cdq_pkg::WORD_W-1:0]  rear_value;
    logic [CW-1:0]                      occupancy;
    logic                               is_empty;
    logic                               is_full;

    // hand-written result travels alongside the transaction
    logic                               item_has_want;
    deque_result_t                      item_want;

    // shadow deque
    logic [cdq_pkg::WORD_W-1:0]         ring_words [DEPTH];
    int unsigned                        head_slot;
    int unsigned                        tail_slot;
    int unsigned                        fill;

    deque_result_t                      pending_results [$];
    int                                 mismatches;
    int                                 items_accepted;
    int                                 results_seen;
    int                                 pushes_done;
    int                                 pops_done;
    int                                 full_refusals;
    int                                 empty_refusals;
    int unsigned                        peak_fill;
    int                                 idle_cycles;

    circular_deque #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .data_in     (data_in),
        .done        (done),
        .status      (status),
        .pop_value   (pop_value),
        .front_value (front_value),
        .rear_value  (rear_value),
        .occupancy   (occupancy),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // apply one operation to the shadow deque and work out its result
    task automatic deque_apply(input cdq_pkg::cdq_kind_t op,
                               input logic signed [cdq_pkg::WORD_W-1:0] word,
                               output deque_result_t res);
        res        = '0;
        res.status = cdq_pkg::STATUS_DONE;
        if (op == cdq_pkg::KIND_PUSH_FRONT || op == cdq_pkg::KIND_PUSH_REAR)
        begin
            if (fill >= DEPTH)
                res.status = cdq_pkg::STATUS_FULL;
            else
            begin
                if (fill == 0)
                begin
                    head_slot = 0;
                    tail_slot = 0;
                    ring_words[0] = word;
                end
                else if (op == cdq_pkg::KIND_PUSH_FRONT)
                begin
                    head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
                    ring_words[head_slot[AW-1:0]] = word;
                end
                else
                begin
                    tail_slot = (tail_slot + 1 >= DEPTH) ? 0 : tail_slot + 1;
                    ring_words[tail_slot[AW-1:0]] = word;
                end
                fill++;
            end
        end
        else
        begin
            if (fill == 0)
                res.status = cdq_pkg::STATUS_EMPTY;
            else if (op == cdq_pkg::KIND_POP_FRONT)
            begin
                res.pop_value = ring_words[head_slot[AW-1:0]];
                if (fill > 1)
                    head_slot = (head_slot + 1 >= DEPTH) ? 0 : head_slot + 1;
                fill--;
            end
            else
            begin
                res.pop_value = ring_words[tail_slot[AW-1:0]];
                if (fill > 1)
                    tail_slot = (tail_slot == 0) ? DEPTH - 1 : tail_slot - 1;
                fill--;
            end
        end
        res.front_value = (fill == 0) ? '0 : ring_words[head_slot[AW-1:0]];
        res.rear_value  = (fill == 0) ? '0 : ring_words[tail_slot[AW-1:0]];
        res.occupancy   = fill[CW-1:0];
        res.is_empty    = (fill == 0);
        res.is_full     = (fill == DEPTH);
    endtask

    // random word, with the extremes showing up often
    function automatic logic signed [cdq_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic cdq_pkg::cdq_kind_t rand_push();
        return cdq_pkg::cdq_kind_t'($urandom_range(0, 1));
    endfunction

    function automatic cdq_pkg::cdq_kind_t rand_pop();
        return cdq_pkg::cdq_kind_t'($urandom_range(2, 3));
    endfunction

    // present one transaction and hold it until taken, then maybe pause
    task automatic issue(input cdq_pkg::cdq_kind_t op,
                         input logic signed [cdq_pkg::WORD_W-1:0] word,
                         input logic has_want, input deque_result_t want, input int idle_odds);
        start         <= 1'b1;
        kind          <= op;
        data_in       <= word;
        item_has_want <= has_want;
        item_want     <= want;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // result checking, prediction on accept, and watchdog
    always @(posedge clk)
    begin : monitor
        deque_result_t seen;
        deque_result_t want;
        deque_result_t predicted;
        logic          accepted;
        if (rst_n)
        begin
            accepted = start && (busy === 1'b0);

            // compare a result transaction with the oldest expectation
            if (done === 1'b1)
            begin
                seen = '{cdq_pkg::cdq_status_t'(status), pop_value, front_value, rear_value,
                         occupancy, is_empty, is_full};
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d arrived with nothing expected", results_seen);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (seen.status !== want.status || seen.pop_value !== want.pop_value ||
                        seen.front_value !== want.front_value ||
                        seen.rear_value !== want.rear_value ||
                        seen.occupancy !== want.occupancy ||
                        seen.is_empty !== want.is_empty || seen.is_full !== want.is_full)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("result %0d mismatch: status %0d/%0d pop %0d/%0d",
                                     results_seen, want.status, seen.status,
                                     want.pop_value, seen.pop_value);
                            $display("  front %0d/%0d rear %0d/%0d count %0d/%0d e %b/%b f %b/%b",
                                     want.front_value, seen.front_value, want.rear_value,
                                     seen.rear_value, want.occupancy, seen.occupancy,
                                     want.is_empty, seen.is_empty, want.is_full, seen.is_full);
                        end
                    end
                end
            end

            // predict the accepted transaction
            if (accepted)
            begin
                deque_apply(cdq_pkg::cdq_kind_t'(kind), data_in, predicted);
                items_accepted++;
                case (predicted.status)
                    cdq_pkg::STATUS_FULL:  full_refusals++;
                    cdq_pkg::STATUS_EMPTY: empty_refusals++;
                    default:
                        if (kind == cdq_pkg::KIND_PUSH_FRONT || kind == cdq_pkg::KIND_PUSH_REAR)
                            pushes_done++;
                        else
                            pops_done++;
                endcase
                if (fill > peak_fill)
                    peak_fill = fill;
                pending_results.push_back(item_has_want ? item_want : predicted);
            end

            // watchdog on cycles with no transaction either way
            if (accepted || done === 1'b1)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                         idle_cycles, pending_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int push_pct;
        int idle_odds;
        int seg_len;
        int random_items;
        rst_n          = 1'b0;
        start          = 1'b0;
        kind           = cdq_pkg::KIND_PUSH_FRONT;
        data_in        = '0;
        item_has_want  = 1'b0;
        item_want      = '0;
        head_slot      = 0;
        tail_slot      = 0;
        fill           = 0;
        mismatches     = 0;
        items_accepted = 0;
        results_seen   = 0;
        pushes_done    = 0;
        pops_done      = 0;
        full_refusals  = 0;
        empty_refusals = 0;
        peak_fill      = 0;
        idle_cycles    = 0;
        foreach (ring_words[i])
            ring_words[i] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (DIRECTED_ROWS[i])
            issue(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].has_want,
                  DIRECTED_ROWS[i].want, 3);

        // random segments, each leaning toward pushes, pops or neither
        random_items = 0;
        while (random_items < 300)
        begin
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 50;
                default: push_pct = 15;
            endcase
            case ($urandom_range(0, 2))
                0:       idle_odds = 0;
                1:       idle_odds = 4;
                default: idle_odds = 2;
            endcase
            seg_len = $urandom_range(20, 60);
            for (int n = 0; n < seg_len; n++)
                issue(($urandom_range(0, 99) < push_pct) ? rand_push() : rand_pop(),
                      rand_word(), 1'b0, NO_RESULT, idle_odds);
            random_items += seg_len;
        end

        // ramp up with pushes, then drain past empty
        for (int n = 0; n < 40; n++)
            issue(rand_push(), rand_word(), 1'b0, NO_RESULT, 16);
        while (fill != 0)
            issue(rand_pop(), rand_word(), 1'b0, NO_RESULT, 16);
        for (int n = 0; n < 10; n++)
            issue(rand_pop(), rand_word(), 1'b0, NO_RESULT, 6);

        // back-to-back tail with no idling
        for (int n = 0; n < 100; n++)
            issue(($urandom_range(0, 99) < 60) ? rand_push() : rand_pop(), rand_word(),
                  1'b0, NO_RESULT, 0);
        start <= 1'b0;

        // drain outstanding results, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("ran %0d transactions: %0d pushes, %0d pops, %0d full and %0d empty refusals",
                 items_accepted, pushes_done, pops_done, full_refusals, empty_refusals);
        $display("peak occupancy %0d of %0d words, %0d results checked, %0d mismatches",
                 peak_fill, DEPTH, results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ circular_deque.f @@
sv/cdq_pkg.sv
sv/cdq_ram.sv
sv/cdq_ctrl.sv
sv/circular_deque.sv
sim/tb_top.sv
